FILE: hdl/mide_pkg.sv
// Shared types and constants for the debouncer with edge events.
package mide_pkg;

  // Threshold register width and the number of channels that raise events.
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned EVENT_CHANS = 6;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned MASK_W      = 8;

  // Register address of the threshold (register index, taken from paddr bit 2).
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd1;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE        = 3'd0,
    EV_OPEN        = 3'd1,
    EV_CLOSE       = 3'd2,
    EV_STOP        = 3'd3,
    EV_LIMIT_OPEN  = 3'd4,
    EV_LIMIT_CLOSE = 3'd5,
    EV_PHOTO_ON    = 3'd6,
    EV_PHOTO_OFF   = 3'd7
  } ev_code_e;

  // Stable levels of the event channels before and after one tick.
  typedef struct packed {
    logic [EVENT_CHANS-1:0] prev;
    logic [EVENT_CHANS-1:0] after;
  } tick_t;

endpackage

FILE: hdl/mide_lane.sv
// One debounce lane: saturating change counter and stable level of a channel.
module mide_lane #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          pin_i,
  input  logic [mide_pkg::THRESH_W-1:0] threshold_i,
  output logic                          stable_o,
  output logic                          stable_next_o
);
  import mide_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic                   stable_q, stable_d;
  logic                   active, differ, flip;
  logic [CMP_W-1:0]       cnt_ext, thr_ext;

  always_comb begin
    active  = ~pin_i;
    differ  = active ^ stable_q;
    cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    cnt_ext = CMP_W'(cnt_inc);
    thr_ext = CMP_W'(threshold_i);
    flip    = differ && (cnt_ext >= thr_ext);
    stable_d = flip ? active : stable_q;
    cnt_d    = (!differ || flip) ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      stable_q <= 1'b0;
    end else if (tick_i) begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
    end
  end

  assign stable_o      = stable_q;
  assign stable_next_o = stable_d;

endmodule

FILE: hdl/mide_merge.sv
// Merges lane results into edge events, sent one per cycle while the receiver keeps up.
module mide_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tick_valid_i,
  output logic                             tick_ready_o,
  input  mide_pkg::tick_t                  tick_i,
  output logic                             ev_valid_o,
  input  logic                             ev_ready_i,
  output mide_pkg::ev_code_e               ev_code_o,
  output logic [mide_pkg::EVENT_CHANS-1:0] ev_levels_o,
  output logic                             ev_last_o
);
  import mide_pkg::*;

  logic                   pend_valid_q, pend_valid_d;
  logic [MASK_W-1:0]      pend_mask_q, pend_mask_d, new_mask, rest;
  logic [EVENT_CHANS-1:0] pend_lev_q, rise;
  logic                   fall;
  logic                   out_valid_q, out_valid_d;
  ev_code_e               out_code_q;
  logic [EVENT_CHANS-1:0] out_lev_q;
  logic                   out_last_q;
  logic                   out_free, take, pend_done, accept;
  logic [CODE_W-1:0]      sel;

  // Mask bit k stands for event code k; bit 0 is set only when no edge occurred.
  always_comb begin
    rise     = tick_i.after & ~tick_i.prev;
    fall     = tick_i.prev[EVENT_CHANS-1] & ~tick_i.after[EVENT_CHANS-1];
    new_mask = {fall, rise, ~(fall | (|rise))};

    sel = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (pend_mask_q[i]) begin
        sel = CODE_W'(i);
      end
    end
    rest = pend_mask_q & (pend_mask_q - MASK_W'(1));

    out_free  = !out_valid_q || ev_ready_i;
    take      = pend_valid_q && out_free;
    pend_done = take && (rest == '0);
    tick_ready_o = !pend_valid_q || pend_done;
    accept    = tick_valid_i && tick_ready_o;

    pend_valid_d = pend_valid_q;
    pend_mask_d  = pend_mask_q;
    if (accept) begin
      pend_valid_d = 1'b1;
      pend_mask_d  = new_mask;
    end else if (pend_done) begin
      pend_valid_d = 1'b0;
    end else if (take) begin
      pend_mask_d = rest;
    end

    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (ev_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_mask_q <= pend_mask_d;
    if (accept) begin
      pend_lev_q <= tick_i.after;
    end
    if (take) begin
      out_code_q <= ev_code_e'(sel);
      out_lev_q  <= pend_lev_q;
      out_last_q <= (rest == '0);
    end
  end

  assign ev_valid_o  = out_valid_q;
  assign ev_code_o   = out_code_q;
  assign ev_levels_o = out_lev_q;
  assign ev_last_o   = out_last_q;

endmodule

FILE: hdl/multi_input_debounce_edge_events.sv
// Top level of the multi-channel debouncer with edge events.
//
// Usage: every transfer on the s_axis side is one scan tick carrying the raw
// pin levels (active low) in s_axis_tdata. Each channel has its own lane with
// a saturating counter; a channel's stable level changes after stable_threshold
// consecutive differing ticks (a threshold of zero acts as one).
// For each tick the m_axis side gives one transfer per debounced edge: rising
// edges of channels 0 to 5 in order (codes 1 to 6), then the falling edge of
// channel 5 (code 7), or a single code 0 transfer when no edge occurred. The
// code travels in m_axis_tuser, the stable levels in m_axis_tdata, and
// m_axis_tlast marks the final transfer of a tick.
// Each tick is held in a pending register, and its results pass one by one
// through the output register, at one per cycle while the receiver accepts
// them. The next tick is taken in the cycle its predecessor's last result
// moves to the output register. When the receiver stalls, the output
// register holds and s_axis_tready drops once one tick is waiting behind it.
// Reset clears all lanes to inactive and sets the threshold to one.
module multi_input_debounce_edge_events #(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // APB-style configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [2:0]                                paddr,
  input  logic [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready,
  // Tick input
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((CHANNELS + 7) / 8) * 8 - 1:0]    s_axis_tdata,  // pin_levels
  // Event output
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [7:0]                                m_axis_tdata,  // stable_levels
  output logic [mide_pkg::CODE_W-1:0]               m_axis_tuser,  // event_code
  output logic                                      m_axis_tlast   // last_of_tick
);
  import mide_pkg::*;

  logic [THRESH_W-1:0]    thresh_q;
  logic [CHANNELS-1:0]    stable, stable_next;
  logic                   tick;
  tick_t                  tick_info;
  ev_code_e               ev_code;
  logic [EVENT_CHANS-1:0] ev_levels;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      thresh_q <= pwdata[THRESH_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thresh_q) : '0;

  assign tick = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mide_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tick_i        (tick),
      .pin_i         (s_axis_tdata[g]),
      .threshold_i   (thresh_q),
      .stable_o      (stable[g]),
      .stable_next_o (stable_next[g])
    );
  end

  // Only the low channels raise events; missing ones read as inactive.
  for (genvar e = 0; e < EVENT_CHANS; e++) begin : g_evch
    if (e < CHANNELS) begin : g_used
      assign tick_info.prev[e]  = stable[e];
      assign tick_info.after[e] = stable_next[e];
    end else begin : g_unused
      assign tick_info.prev[e]  = 1'b0;
      assign tick_info.after[e] = 1'b0;
    end
  end

  mide_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_o (s_axis_tready),
    .tick_i       (tick_info),
    .ev_valid_o   (m_axis_tvalid),
    .ev_ready_i   (m_axis_tready),
    .ev_code_o    (ev_code),
    .ev_levels_o  (ev_levels),
    .ev_last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = ev_code;
  assign m_axis_tdata = 8'(ev_levels);

endmodule

FILE: test/testbench.sv
// Testbench for the six-channel debouncer with edge events, self-checking.
`timescale 1ns / 1ps

module testbench;
  import mide_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0]  ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
  localparam int unsigned MAX_GAP = 17;

  typedef struct packed {
    ev_code_e   code;
    logic [5:0] levels;
    logic       last;
  } edge_event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // pin_levels[5:0], zero pad [7:6]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // stable_levels[5:0], zero pad [7:6]
  logic [2:0]  m_axis_tuser;   // event_code[2:0]
  logic        m_axis_tlast;

  // Debounce state tracked alongside the block.
  logic [7:0]  deb_threshold;
  logic [5:0]  deb_stable;
  logic [7:0]  deb_count [6];
  edge_event_t pending_events [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_cycles;

  multi_input_debounce_edge_events i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Advances the debounce state by one tick and queues the events it raises.
  task automatic predict_edge_events(input logic [5:0] pins);
    ev_code_e    rise_code [6];
    edge_event_t evs [7];
    logic [5:0]  prior;
    logic        active;
    int unsigned n;
    rise_code = '{EV_OPEN, EV_CLOSE, EV_STOP, EV_LIMIT_OPEN, EV_LIMIT_CLOSE, EV_PHOTO_ON};
    prior = deb_stable;
    n = 0;
    for (int i = 0; i < 6; i++) begin
      active = ~pins[i];
      if (active == deb_stable[i]) begin
        deb_count[i] = 8'd0;
      end else begin
        if (deb_count[i] != 8'hFF) deb_count[i] = deb_count[i] + 8'd1;
        if (deb_count[i] >= deb_threshold) begin
          deb_stable[i] = active;
          deb_count[i]  = 8'd0;
        end
      end
    end
    for (int i = 0; i < 6; i++) begin
      if (deb_stable[i] && !prior[i]) begin
        evs[n] = '{code: rise_code[i], levels: deb_stable, last: 1'b0};
        n++;
      end
    end
    if (!deb_stable[5] && prior[5]) begin
      evs[n] = '{code: EV_PHOTO_OFF, levels: deb_stable, last: 1'b0};
      n++;
    end
    if (n == 0) begin
      evs[0] = '{code: EV_NONE, levels: deb_stable, last: 1'b0};
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      evs[k].last = (k == n - 1);
      pending_events.push_back(evs[k]);
    end
  endtask

  task automatic send_tick(input logic [5:0] pins);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pins};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_edge_events(pins);
  endtask

  // Stops offering ticks and waits until every expected event has arrived.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_THRESHOLD) deb_threshold = data[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] expected);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== expected) begin
      report_mismatch($sformatf("read of 0x%0h gave 0x%0h, expected 0x%0h",
                                addr, prdata, expected));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker: each transfer is compared against the oldest expectation.
  always @(posedge clk_i) begin
    edge_event_t exp_ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event code %0d", m_axis_tuser));
      end else begin
        exp_ev = pending_events.pop_front();
        if (m_axis_tuser !== exp_ev.code) begin
          report_mismatch($sformatf("event code %0d, expected %0d",
                                    m_axis_tuser, exp_ev.code));
        end
        if (m_axis_tdata !== {2'b00, exp_ev.levels}) begin
          report_mismatch($sformatf("stable levels 0x%0h, expected 0x%0h",
                                    m_axis_tdata, exp_ev.levels));
        end
        if (m_axis_tlast !== exp_ev.last) begin
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast, exp_ev.last));
        end
      end
    end
  end

  // Receiver: random stalls per transfer, plus a long hold when one is requested.
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_reset_value();
    apb_read_check(ADDR_THRESHOLD, {24'd0, THRESH_RESET});
  endtask

  // Threshold one: every edge code, the no-event case and simultaneous edges.
  task automatic test_edge_order();
    send_tick(6'h3F);
    send_tick(6'h00);
    send_tick(6'h00);
    send_tick(6'h3F);
    for (int i = 0; i < 6; i++) begin
      send_tick(~(6'h01 << i));
      send_tick(6'h3F);
    end
    send_tick(6'h15);
    send_tick(6'h2A);
    wait_idle();
  endtask

  // A threshold of zero flips on the first differing sample.
  task automatic test_zero_threshold();
    apb_write(ADDR_THRESHOLD, 32'd0);
    apb_read_check(ADDR_THRESHOLD, 32'd0);
    send_tick(6'h00);
    send_tick(6'h3F);
    wait_idle();
  endtask

  // A counter left above a newly lowered threshold flips on the next differing sample.
  task automatic test_threshold_lowered();
    apb_write(ADDR_THRESHOLD, 32'd10);
    repeat (4) send_tick(6'h1E);
    wait_idle();
    apb_write(ADDR_THRESHOLD, 32'd2);
    send_tick(6'h1E);
    send_tick(6'h3F);
    send_tick(6'h3F);
    wait_idle();
  endtask

  task automatic test_unknown_register();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    apb_read_check(ADDR_THRESHOLD, 32'd2);
    send_tick(6'h00);
    wait_idle();
  endtask

  // Largest threshold: every channel differs for 60 ticks without flipping, and
  // all of them flip once the threshold drops to 60.
  task automatic test_max_threshold();
    logic [5:0] pins;
    apb_write(ADDR_THRESHOLD, 32'd255);
    apb_read_check(ADDR_THRESHOLD, 32'd255);
    tx_idle_on = 1'b0;
    pins = deb_stable;
    repeat (60) send_tick(pins);
    wait_idle();
    apb_write(ADDR_THRESHOLD, 32'd60);
    send_tick(pins);
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  // The receiver holds off while ticks keep coming, so the block stalls its input.
  task automatic test_backpressure();
    apb_write(ADDR_THRESHOLD, 32'd1);
    tx_idle_on = 1'b0;
    rx_hold_cycles = 80;
    for (int k = 0; k < 12; k++) begin
      send_tick(k[0] ? 6'h3F : 6'h00);
    end
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  // Patterns held for runs near the threshold, with occasional bounce samples.
  task automatic test_random_ticks(input logic [7:0] thr, input int unsigned n_ticks,
                                   input bit tx_on, input bit rx_on);
    int unsigned sent;
    int unsigned run;
    logic [5:0]  target;
    apb_write(ADDR_THRESHOLD, {24'd0, thr});
    tx_idle_on = tx_on;
    rx_idle_on = rx_on;
    sent = 0;
    while (sent < n_ticks) begin
      target = 6'($urandom);
      run = $urandom_range(1, int'(thr) + 3);
      for (int k = 0; k < run && sent < n_ticks; k++) begin
        if ($urandom_range(0, 7) == 0) send_tick(6'($urandom));
        else send_tick(target);
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_cycles = 0;
    deb_threshold  = THRESH_RESET;
    deb_stable     = '0;
    for (int i = 0; i < 6; i++) deb_count[i] = 8'd0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_value();
    test_edge_order();
    test_zero_threshold();
    test_threshold_lowered();
    test_unknown_register();
    test_max_threshold();
    test_backpressure();
    test_random_ticks(8'd1, 37, 1'b1, 1'b1);
    test_random_ticks(8'd3, 37, 1'b0, 1'b0);
    test_random_ticks(8'($urandom_range(0, 6)), 37, 1'b1, 1'b0);
    test_random_ticks(8'd2, 37, 1'b0, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
